// File: rtl/core/rlps_pkg.sv
package rlps_pkg;

  localparam int unsigned LVL_W = 8;

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_SET   = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // pattern codes
  localparam logic [4:0] PAT_OFF         = 5'd0;
  localparam logic [4:0] PAT_HOLD_LAST   = 5'd4;
  localparam logic [4:0] PAT_BLINK_FIRST = 5'd5;
  localparam logic [4:0] PAT_BLINK_LAST  = 5'd8;
  localparam logic [4:0] PAT_FLASH_FIRST = 5'd9;
  localparam logic [4:0] PAT_FLASH_LAST  = 5'd12;
  localparam logic [4:0] PAT_RAINBOW     = 5'd13;
  localparam logic [4:0] PAT_REVERSE     = 5'd14;
  localparam logic [4:0] PAT_ERROR       = 5'd15;
  localparam logic [4:0] PAT_START       = 5'd16;

  // register indexes
  localparam logic [1:0] REG_BLINK     = 2'd0;
  localparam logic [1:0] REG_RAMP_STEP = 2'd1;
  localparam logic [1:0] REG_END_HOLD  = 2'd2;
  localparam logic [1:0] REG_ERROR     = 2'd3;

  localparam logic [9:0] BLINK_RST     = 10'd500;
  localparam logic [5:0] RAMP_STEP_RST = 6'd5;
  localparam logic [7:0] END_HOLD_RST  = 8'd50;
  localparam logic [9:0] ERROR_RST     = 10'd200;

  localparam logic [4:0] RAINBOW_LAST  = 5'd7;
  localparam logic [2:0] ERROR_REPEATS = 3'd4;
  localparam logic [7:0] LVL_MAX       = 8'd255;

  localparam logic [4:0] PHASES_BLINK  = 5'd2;
  localparam logic [4:0] PHASES_FLASH  = 5'd6;
  localparam logic [4:0] PHASES_START  = 5'd22;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] red_in;
    logic signed [15:0] green_in;
    logic signed [15:0] blue_in;
    logic [4:0]         pattern;
  } rlps_item_t;

  typedef struct packed {
    logic [LVL_W-1:0] red_level;
    logic [LVL_W-1:0] green_level;
    logic [LVL_W-1:0] blue_level;
    logic             busy_res;
    logic             finished;
  } rlps_res_t;

  typedef struct packed {
    logic [9:0] blink_ms;
    logic [5:0] ramp_step_ms;
    logic [7:0] end_hold_ms;
    logic [9:0] error_ms;
  } rlps_cfg_t;

  typedef struct packed {
    logic [4:0]       active_pattern;
    logic [4:0]       phase_index;
    logic [8:0]       level_step;
    logic [9:0]       tick_count;
    logic [2:0]       repeat_count;
    logic [LVL_W-1:0] red_now;
    logic [LVL_W-1:0] green_now;
    logic [LVL_W-1:0] blue_now;
  } rlps_state_t;

  typedef struct packed {
    logic             en;
    logic [LVL_W-1:0] r;
    logic [LVL_W-1:0] g;
    logic [LVL_W-1:0] b;
  } rlps_show_t;

  typedef struct packed {
    logic [LVL_W-1:0] r;
    logic [LVL_W-1:0] g;
    logic [LVL_W-1:0] b;
    logic [1:0]       chan;
    logic             up;
  } rlps_ramp_t;

  function automatic logic [LVL_W-1:0] clamp_lvl(input logic signed [15:0] v);
    if (v[15]) begin
      return '0;
    end else if (v[14:8] != 7'd0) begin
      return LVL_MAX;
    end else begin
      return v[7:0];
    end
  endfunction

  function automatic logic is_blinker(input logic [4:0] p);
    return (p >= PAT_BLINK_FIRST && p <= PAT_FLASH_LAST) || p == PAT_START;
  endfunction

  // 0 white, 1 red, 2 green, 3 blue
  function automatic rlps_show_t base_col(input logic [1:0] idx);
    rlps_show_t s;
    s.en = 1'b1;
    case (idx)
      2'd0:    begin s.r = LVL_MAX; s.g = LVL_MAX; s.b = LVL_MAX; end
      2'd1:    begin s.r = LVL_MAX; s.g = '0;      s.b = '0;      end
      2'd2:    begin s.r = '0;      s.g = LVL_MAX; s.b = '0;      end
      default: begin s.r = '0;      s.g = '0;      s.b = LVL_MAX; end
    endcase
    return s;
  endfunction

  // ramp sequence per phase: fixed colour, ramped channel, direction
  function automatic rlps_ramp_t ramp_entry(input logic rev, input logic [2:0] idx);
    rlps_ramp_t e;
    e = '0;
    case ({rev, idx})
      4'b0_000: begin e.r = LVL_MAX; e.chan = 2'd1; e.up = 1'b1; end
      4'b0_001: begin e.g = LVL_MAX; e.chan = 2'd0; e.up = 1'b0; end
      4'b0_010: begin e.g = LVL_MAX; e.chan = 2'd2; e.up = 1'b1; end
      4'b0_011: begin e.b = LVL_MAX; e.chan = 2'd1; e.up = 1'b0; end
      4'b0_100: begin e.b = LVL_MAX; e.chan = 2'd0; e.up = 1'b1; end
      4'b0_101: begin e.r = LVL_MAX; e.chan = 2'd2; e.up = 1'b0; end
      4'b1_000: begin e.r = LVL_MAX; e.chan = 2'd2; e.up = 1'b1; end
      4'b1_001: begin e.b = LVL_MAX; e.chan = 2'd0; e.up = 1'b0; end
      4'b1_010: begin e.b = LVL_MAX; e.chan = 2'd1; e.up = 1'b1; end
      4'b1_011: begin e.g = LVL_MAX; e.chan = 2'd2; e.up = 1'b0; end
      4'b1_100: begin e.g = LVL_MAX; e.chan = 2'd0; e.up = 1'b1; end
      4'b1_101: begin e.r = LVL_MAX; e.chan = 2'd1; e.up = 1'b0; end
      default:  e = '0;
    endcase
    return e;
  endfunction

  // colour shown for a given pattern position; en low means levels are left as they are
  function automatic rlps_show_t show_colour(input logic [4:0] p, input logic [4:0] ph,
                                             input logic [8:0] ls);
    rlps_show_t s;
    rlps_ramp_t e;
    logic [4:0] rel;
    logic [LVL_W-1:0] v;
    s = '0;
    e = '0;
    rel = '0;
    v = '0;
    if (is_blinker(p)) begin
      if (ph[0]) begin
        s.en = 1'b1;
      end else if (p <= PAT_BLINK_LAST) begin
        rel = p - PAT_BLINK_FIRST;
        s = base_col(rel[1:0]);
      end else if (p <= PAT_FLASH_LAST) begin
        rel = p - PAT_FLASH_FIRST;
        s = base_col(rel[1:0]);
      end else begin
        // start sequence: white, three red, three green, three blue, white
        case (ph[4:1])
          4'd1, 4'd2, 4'd3: s = base_col(2'd1);
          4'd4, 4'd5, 4'd6: s = base_col(2'd2);
          4'd7, 4'd8, 4'd9: s = base_col(2'd3);
          default:          s = base_col(2'd0);
        endcase
      end
    end else if (p == PAT_ERROR) begin
      s.en = 1'b1;
      s.r  = ph[0] ? '0 : LVL_MAX;
      s.g  = ph[0] ? LVL_MAX : '0;
      s.b  = LVL_MAX;
    end else if (p == PAT_RAINBOW || p == PAT_REVERSE) begin
      if (ph == 5'd0) begin
        s = base_col(2'd1);
      end else if (ph < RAINBOW_LAST) begin
        rel = ph - 5'd1;
        e = ramp_entry(p == PAT_REVERSE, rel[2:0]);
        v = e.up ? ls[7:0] : LVL_MAX - ls[7:0];
        s.en = 1'b1;
        s.r = (e.chan == 2'd0) ? v : e.r;
        s.g = (e.chan == 2'd1) ? v : e.g;
        s.b = (e.chan == 2'd2) ? v : e.b;
      end
    end
    return s;
  endfunction

endpackage

// File: rtl/core/rlps_cfg.sv
module rlps_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_wdata,
  output rlps_pkg::rlps_cfg_t cfg
);
  import rlps_pkg::*;

  rlps_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blink_ms     <= BLINK_RST;
      cfg_r.ramp_step_ms <= RAMP_STEP_RST;
      cfg_r.end_hold_ms  <= END_HOLD_RST;
      cfg_r.error_ms     <= ERROR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLINK:     cfg_r.blink_ms     <= cfg_wdata;
        REG_RAMP_STEP: cfg_r.ramp_step_ms <= cfg_wdata[5:0];
        REG_END_HOLD:  cfg_r.end_hold_ms  <= cfg_wdata[7:0];
        REG_ERROR:     cfg_r.error_ms     <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/rlps_step.sv
module rlps_step (
  input  rlps_pkg::rlps_item_t  item,
  input  rlps_pkg::rlps_cfg_t   cfg,
  input  rlps_pkg::rlps_state_t st,
  output rlps_pkg::rlps_state_t st_nxt,
  output rlps_pkg::rlps_res_t   res
);
  import rlps_pkg::*;

  rlps_state_t nx;
  rlps_show_t  sh;
  rlps_ramp_t  ramp;
  logic        do_show;
  logic        fin;
  logic [10:0] tc_inc;
  logic [9:0]  len;
  logic [5:0]  ph_inc;
  logic [4:0]  phases;
  logic [4:0]  ph_rel;
  logic [8:0]  ls_inc;
  logic [2:0]  rep_inc;

  always_comb begin
    nx      = st;
    do_show = 1'b0;
    fin     = 1'b0;
    tc_inc  = {1'b0, st.tick_count} + 11'd1;
    ph_inc  = {1'b0, st.phase_index} + 6'd1;
    ph_rel  = st.phase_index - 5'd1;
    ramp    = ramp_entry(st.active_pattern == PAT_REVERSE, ph_rel[2:0]);
    ls_inc  = st.level_step + 9'd1;
    rep_inc = st.repeat_count + 3'd1;

    if (st.active_pattern <= PAT_BLINK_LAST) begin
      phases = PHASES_BLINK;
    end else if (st.active_pattern <= PAT_FLASH_LAST) begin
      phases = PHASES_FLASH;
    end else begin
      phases = PHASES_START;
    end

    if (is_blinker(st.active_pattern)) begin
      len = cfg.blink_ms;
    end else if (st.active_pattern == PAT_ERROR) begin
      len = cfg.error_ms;
    end else if (st.phase_index == 5'd0 || st.phase_index >= RAINBOW_LAST) begin
      len = {2'd0, cfg.end_hold_ms};
    end else begin
      len = {4'd0, cfg.ramp_step_ms};
    end
    if (len == 10'd0) begin
      len = 10'd1;
    end

    case (item.action)
      ACT_TICK: begin
        if (st.active_pattern != PAT_OFF) begin
          if (tc_inc < {1'b0, len}) begin
            nx.tick_count = tc_inc[9:0];
          end else begin
            nx.tick_count = '0;
            do_show = 1'b1;
            if (is_blinker(st.active_pattern)) begin
              if (ph_inc >= {1'b0, phases}) begin
                nx.active_pattern = PAT_OFF;
                fin = 1'b1;
                do_show = 1'b0;
              end else begin
                nx.phase_index = ph_inc[4:0];
              end
            end else if (st.active_pattern == PAT_ERROR) begin
              if (st.phase_index == 5'd0) begin
                nx.phase_index = 5'd1;
              end else begin
                nx.phase_index  = '0;
                nx.repeat_count = rep_inc;
                if (rep_inc >= ERROR_REPEATS) begin
                  nx.red_now = '0;
                  nx.green_now = '0;
                  nx.blue_now = '0;
                  nx.active_pattern = PAT_OFF;
                  fin = 1'b1;
                  do_show = 1'b0;
                end
              end
            end else begin
              if (st.phase_index >= RAINBOW_LAST) begin
                nx.active_pattern = PAT_OFF;
                fin = 1'b1;
                do_show = 1'b0;
              end else if (st.phase_index == 5'd0) begin
                nx.phase_index = 5'd1;
                nx.level_step  = '0;
              end else if (ls_inc >= (ramp.up ? 9'd256 : 9'd255)) begin
                // ramp done, move to the next one
                nx.level_step  = '0;
                nx.phase_index = ph_inc[4:0];
              end else begin
                nx.level_step = ls_inc;
              end
            end
          end
        end
      end
      ACT_SET: begin
        nx.red_now        = clamp_lvl(item.red_in);
        nx.green_now      = clamp_lvl(item.green_in);
        nx.blue_now       = clamp_lvl(item.blue_in);
        nx.active_pattern = PAT_OFF;
      end
      ACT_START: begin
        if (item.pattern == PAT_OFF) begin
          nx.red_now = '0;
          nx.green_now = '0;
          nx.blue_now = '0;
          nx.active_pattern = PAT_OFF;
        end else if (item.pattern <= PAT_HOLD_LAST) begin
          sh = base_col(item.pattern[1:0] - 2'd1);
          nx.red_now = sh.r;
          nx.green_now = sh.g;
          nx.blue_now = sh.b;
          nx.active_pattern = PAT_OFF;
        end else if (item.pattern <= PAT_START) begin
          nx.active_pattern = item.pattern;
          nx.phase_index    = '0;
          nx.level_step     = '0;
          nx.tick_count     = '0;
          nx.repeat_count   = '0;
          do_show = 1'b1;
        end
      end
      default: ;
    endcase

    sh = show_colour(nx.active_pattern, nx.phase_index, nx.level_step);
    if (do_show && sh.en) begin
      nx.red_now   = sh.r;
      nx.green_now = sh.g;
      nx.blue_now  = sh.b;
    end
  end

  assign st_nxt = nx;

  assign res.red_level   = nx.red_now;
  assign res.green_level = nx.green_now;
  assign res.blue_level  = nx.blue_now;
  assign res.busy_res    = nx.active_pattern != PAT_OFF;
  assign res.finished    = fin;

endmodule

// File: rtl/core/rgb_led_pattern_sequencer.sv
// RGB LED pattern sequencer.
// in_* : one word per command. in_tuser[1:0] is the action (tick, direct set,
//   pattern start); in_tdata carries the signed red/green/blue requests and
//   the pattern code. A tick stands for one millisecond of pattern time.
// out_*: exactly one result word per command, with the three channel levels,
//   a busy flag while a timed pattern runs and a finished flag on the tick
//   that ends one.
// cfg_*: write-only register port (blink, ramp step, end hold, error phase
//   lengths in ticks); write it only while no word is in flight (not enforced here).
// Path: a command word taken is held in the input register; its result is then
//   written to the result register fed by the step logic and shown on out_tvalid.
// Throughput: one word per cycle unless the receiver stalls; the state update is a
//   single pass of counter, compare and small table logic between the two registers.
// Reset clears the pattern state and levels to off and loads the register
//   defaults. When the receiver stalls, the result register holds its word
//   and the input register takes one more word before in_tready falls.
module rgb_led_pattern_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // red_in[15:0], green_in[31:16], blue_in[47:32],
                                  // pattern[52:48], zero pad
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // red_level[7:0], green_level[15:8],
                                  // blue_level[23:16], busy_res[24], finished[25], pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_wdata
);
  import rlps_pkg::*;

  rlps_cfg_t   cfg;
  rlps_item_t  in_item_r;
  logic        in_valid_r;
  rlps_state_t st_r;
  rlps_state_t st_nxt;
  rlps_res_t   res_nxt;
  rlps_res_t   out_data_r;
  logic        out_valid_r;
  logic        adv;

  rlps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rlps_step u_step (
    .item   (in_item_r),
    .cfg    (cfg),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        st_r <= st_nxt;
      end
      out_valid_r <= adv || (out_valid_r && !out_tready);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.action   <= in_tuser;
      in_item_r.red_in   <= in_tdata[15:0];
      in_item_r.green_in <= in_tdata[31:16];
      in_item_r.blue_in  <= in_tdata[47:32];
      in_item_r.pattern  <= in_tdata[52:48];
    end
    if (adv) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_data_r.finished, out_data_r.busy_res,
                       out_data_r.blue_level, out_data_r.green_level,
                       out_data_r.red_level};

  a_fin_not_busy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.finished |-> !out_data_r.busy_res)
    else $error("finished word still reports busy");

  a_set_cancels : assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_item_r.action == ACT_SET |=> st_r.active_pattern == PAT_OFF)
    else $error("direct set left a pattern running");

  a_rainbow_phase : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.active_pattern == PAT_RAINBOW || st_r.active_pattern == PAT_REVERSE
    |-> st_r.phase_index <= RAINBOW_LAST)
    else $error("rainbow phase out of range");

  a_error_repeats : assert property (@(posedge clk) disable iff (!rst_n)
    st_r.active_pattern == PAT_ERROR |-> st_r.repeat_count < ERROR_REPEATS)
    else $error("error blink ran past its repeat count");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while both stages are full");

endmodule

// File: dv/rgb_led_pattern_sequencer_tb.sv
`timescale 1ns / 100ps

module rgb_led_pattern_sequencer_tb;
  import rlps_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_PCT = 6;
  // ramp steps in one rainbow: three up-ramps of 256 and three down-ramps of 255
  localparam int RAMP_STEPS = 1533;

  typedef enum logic [1:0] {C_WHITE, C_RED, C_GREEN, C_BLUE} hue_e;
  typedef enum logic [1:0] {CH_R, CH_G, CH_B} chan_e;

  typedef struct packed {
    hue_e  base;
    chan_e chan;
    logic  up;
  } ramp_seg_t;

  class led_tracker;
    logic [9:0] blink_len;
    logic [5:0] ramp_len;
    logic [7:0] hold_len;
    logic [9:0] err_len;
    logic [4:0] pat;
    logic [4:0] phase;
    logic [8:0] step;
    logic [9:0] ticks;
    logic [2:0] pairs;
    logic [7:0] r, g, b;
    rlps_res_t  levels_due[$];
    int         fails;
    int         mismatches;

    function new();
      blink_len  = BLINK_RST;
      ramp_len   = RAMP_STEP_RST;
      hold_len   = END_HOLD_RST;
      err_len    = ERROR_RST;
      pat        = PAT_OFF;
      phase      = '0;
      step       = '0;
      ticks      = '0;
      pairs      = '0;
      r          = '0;
      g          = '0;
      b          = '0;
      fails      = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [9:0] v);
      case (idx)
        REG_BLINK:     blink_len = v;
        REG_RAMP_STEP: ramp_len  = v[5:0];
        REG_END_HOLD:  hold_len  = v[7:0];
        REG_ERROR:     err_len   = v;
      endcase
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function void paint(logic [7:0] rv, logic [7:0] gv, logic [7:0] bv);
      r = rv;
      g = gv;
      b = bv;
    endfunction

    function void paint_hue(hue_e h);
      case (h)
        C_WHITE: paint(LVL_MAX, LVL_MAX, LVL_MAX);
        C_RED:   paint(LVL_MAX, 8'd0, 8'd0);
        C_GREEN: paint(8'd0, LVL_MAX, 8'd0);
        C_BLUE:  paint(8'd0, 8'd0, LVL_MAX);
      endcase
    endfunction

    function bit blinks(logic [4:0] p);
      return (p >= PAT_BLINK_FIRST && p <= PAT_FLASH_LAST) || p == PAT_START;
    endfunction

    function int blink_phases(logic [4:0] p);
      if (p <= PAT_BLINK_LAST) return 2;
      if (p <= PAT_FLASH_LAST) return 6;
      return 22;
    endfunction

    function hue_e blink_hue(logic [4:0] p, logic [4:0] ph);
      int n;
      n = ph >> 1;
      if (p <= PAT_BLINK_LAST) return hue_e'(p - PAT_BLINK_FIRST);
      if (p <= PAT_FLASH_LAST) return hue_e'(p - PAT_FLASH_FIRST);
      if (n == 0 || n >= 10) return C_WHITE;
      return hue_e'(1 + (n - 1) / 3);
    endfunction

    // colour held on the other channels, ramped channel and direction
    function ramp_seg_t ramp_seg(logic rev, logic [2:0] idx);
      ramp_seg_t s;
      s = '{C_RED, CH_G, 1'b1};
      case ({rev, idx})
        4'b0_000: s = '{C_RED,   CH_G, 1'b1};
        4'b0_001: s = '{C_GREEN, CH_R, 1'b0};
        4'b0_010: s = '{C_GREEN, CH_B, 1'b1};
        4'b0_011: s = '{C_BLUE,  CH_G, 1'b0};
        4'b0_100: s = '{C_BLUE,  CH_R, 1'b1};
        4'b0_101: s = '{C_RED,   CH_B, 1'b0};
        4'b1_000: s = '{C_RED,   CH_B, 1'b1};
        4'b1_001: s = '{C_BLUE,  CH_R, 1'b0};
        4'b1_010: s = '{C_BLUE,  CH_G, 1'b1};
        4'b1_011: s = '{C_GREEN, CH_B, 1'b0};
        4'b1_100: s = '{C_GREEN, CH_R, 1'b1};
        4'b1_101: s = '{C_RED,   CH_G, 1'b0};
        default:  s = '{C_RED,   CH_G, 1'b1};
      endcase
      return s;
    endfunction

    function void show();
      ramp_seg_t  seg;
      logic [7:0] v;
      if (blinks(pat)) begin
        if (phase[0]) paint(8'd0, 8'd0, 8'd0);
        else paint_hue(blink_hue(pat, phase));
      end else if (pat == PAT_ERROR) begin
        if (phase[0]) paint(8'd0, LVL_MAX, LVL_MAX);
        else paint(LVL_MAX, 8'd0, LVL_MAX);
      end else if (pat == PAT_RAINBOW || pat == PAT_REVERSE) begin
        if (phase == 5'd0) begin
          paint_hue(C_RED);
        end else if (phase < RAINBOW_LAST) begin
          // the end hold leaves the levels as the last ramp left them
          seg = ramp_seg(pat == PAT_REVERSE, 3'(phase - 5'd1));
          v = seg.up ? step[7:0] : LVL_MAX - step[7:0];
          paint_hue(seg.base);
          case (seg.chan)
            CH_R:    r = v;
            CH_G:    g = v;
            default: b = v;
          endcase
        end
      end
    endfunction

    function int phase_len();
      int d;
      if (blinks(pat)) d = blink_len;
      else if (pat == PAT_ERROR) d = err_len;
      else if (phase == 5'd0 || phase >= RAINBOW_LAST) d = hold_len;
      else d = ramp_len;
      return (d == 0) ? 1 : d;
    endfunction

    // one millisecond of pattern time; returns 1 when the pattern completes
    function bit advance_tick();
      ramp_seg_t seg;
      int        len;
      ticks = ticks + 10'd1;
      if (ticks < phase_len()) return 1'b0;
      ticks = '0;
      if (blinks(pat)) begin
        if (phase + 1 >= blink_phases(pat)) begin
          pat = PAT_OFF;
          return 1'b1;
        end
        phase = phase + 5'd1;
      end else if (pat == PAT_ERROR) begin
        if (phase == 5'd0) begin
          phase = 5'd1;
        end else begin
          phase = 5'd0;
          pairs = pairs + 3'd1;
          if (pairs >= ERROR_REPEATS) begin
            paint(8'd0, 8'd0, 8'd0);
            pat = PAT_OFF;
            return 1'b1;
          end
        end
      end else begin
        if (phase >= RAINBOW_LAST) begin
          pat = PAT_OFF;
          return 1'b1;
        end
        if (phase == 5'd0) begin
          phase = 5'd1;
          step = '0;
        end else begin
          seg = ramp_seg(pat == PAT_REVERSE, 3'(phase - 5'd1));
          len = seg.up ? 256 : 255;
          step = step + 9'd1;
          if (step >= len) begin
            step = '0;
            phase = phase + 5'd1;
          end
        end
      end
      show();
      return 1'b0;
    endfunction

    function logic [7:0] clip(logic signed [15:0] v);
      if (v < 0) return 8'd0;
      if (v > 255) return LVL_MAX;
      return v[7:0];
    endfunction

    function rlps_res_t next_levels(rlps_item_t it);
      rlps_res_t res;
      logic      fin;
      fin = 1'b0;
      case (it.action)
        ACT_TICK: begin
          if (pat != PAT_OFF && advance_tick()) fin = 1'b1;
        end
        ACT_SET: begin
          paint(clip(it.red_in), clip(it.green_in), clip(it.blue_in));
          pat = PAT_OFF;
        end
        ACT_START: begin
          if (it.pattern == PAT_OFF) begin
            paint(8'd0, 8'd0, 8'd0);
            pat = PAT_OFF;
          end else if (it.pattern <= PAT_HOLD_LAST) begin
            paint_hue(hue_e'(it.pattern - 5'd1));
            pat = PAT_OFF;
          end else if (it.pattern <= PAT_START) begin
            pat   = it.pattern;
            phase = '0;
            step  = '0;
            ticks = '0;
            pairs = '0;
            show();
          end
        end
        default: ;
      endcase
      res.red_level   = r;
      res.green_level = g;
      res.blue_level  = b;
      res.busy_res    = (pat != PAT_OFF);
      res.finished    = fin;
      return res;
    endfunction

    function void note_command(rlps_item_t it);
      levels_due.push_back(next_levels(it));
    endfunction

    function void check_word(logic [31:0] d);
      rlps_res_t want, got;
      got.red_level   = d[7:0];
      got.green_level = d[15:8];
      got.blue_level  = d[23:16];
      got.busy_res    = d[24];
      got.finished    = d[25];
      if (levels_due.size() == 0) begin
        fails++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", d);
        return;
      end
      want = levels_due.pop_front();
      if (got.red_level !== want.red_level || got.green_level !== want.green_level ||
          got.blue_level !== want.blue_level || got.busy_res !== want.busy_res ||
          got.finished !== want.finished) begin
        fails++;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want %0d/%0d/%0d busy=%0b fin=%0b, got %0d/%0d/%0d busy=%0b fin=%0b",
                   want.red_level, want.green_level, want.blue_level, want.busy_res,
                   want.finished, got.red_level, got.green_level, got.blue_level,
                   got.busy_res, got.finished);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;   // red_in[15:0], green_in[31:16], blue_in[47:32], pattern[52:48]
  logic [1:0]  in_tuser = ACT_TICK;  // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // red[7:0], green[15:8], blue[23:16], busy[24], finished[25]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_BLINK;
  logic [9:0]  cfg_wdata = '0;

  led_tracker tracker = new();
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;
  int         words_sent = 0;
  int         cycles = 0;

  rgb_led_pattern_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: checks every word taken, stalls at random unless calm, and holds off when a squeeze is requested
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) tracker.check_word(out_tdata);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [15:0] rv, input logic [15:0] gv,
                           input logic [15:0] bv, input logic [4:0] pv);
    rlps_item_t it;
    it.action   = act;
    it.red_in   = rv;
    it.green_in = gv;
    it.blue_in  = bv;
    it.pattern  = pv;
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, pv, bv, gv, rv};
    do @(posedge clk); while (!in_tready);
    tracker.note_command(it);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(ACT_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 5'($urandom));
  endtask

  task automatic send_noise();
    send_word(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 5'($urandom));
  endtask

  function automatic logic [15:0] rnd_level();
    case ($urandom_range(2))
      0:       return 16'($urandom_range(0, 300));
      1:       return 16'(-$urandom_range(1, 300));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [9:0] bl, input logic [9:0] rs, input logic [9:0] eh,
                          input logic [9:0] er);
    logic [1:0] regs[4];
    logic [9:0] vals[4];
    regs = '{REG_BLINK, REG_RAMP_STEP, REG_END_HOLD, REG_ERROR};
    vals = '{bl, rs, eh, er};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      tracker.write_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // one start or set followed by ticks, or a lone stray word; short patterns mostly run to completion
  task automatic run_sequence();
    int         pick, n, full, ub, ur, uh, ue;
    logic [4:0] p;
    ub = (tracker.blink_len == 0) ? 1 : tracker.blink_len;
    ur = (tracker.ramp_len == 0) ? 1 : tracker.ramp_len;
    uh = (tracker.hold_len == 0) ? 1 : tracker.hold_len;
    ue = (tracker.err_len == 0) ? 1 : tracker.err_len;
    pick = $urandom_range(99);
    if (pick < 8) begin
      send_noise();
    end else if (pick < 20) begin
      send_word(ACT_SET, rnd_level(), rnd_level(), rnd_level(), 5'($urandom));
      repeat ($urandom_range(0, 3)) send_tick();
    end else begin
      if ($urandom_range(99) < 10) p = 5'($urandom);
      else p = 5'($urandom_range(PAT_BLINK_FIRST, PAT_START));
      if (p >= PAT_BLINK_FIRST && p <= PAT_BLINK_LAST) full = 2 * ub;
      else if (p >= PAT_FLASH_FIRST && p <= PAT_FLASH_LAST) full = 6 * ub;
      else if (p == PAT_START) full = 22 * ub;
      else if (p == PAT_ERROR) full = 8 * ue;
      else if (p == PAT_RAINBOW || p == PAT_REVERSE) full = 2 * uh + RAMP_STEPS * ur;
      else full = 0;
      send_word(ACT_START, 16'($urandom), 16'($urandom), 16'($urandom), p);
      if (full <= 120 && $urandom_range(99) < 75) n = full + $urandom_range(0, 3);
      else n = $urandom_range(1, 40);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 3) send_noise();
        else send_tick();
      end
    end
  endtask

  task automatic run_phase(input logic [9:0] bl, input logic [9:0] rs, input logic [9:0] eh,
                           input logic [9:0] er, input int budget, input bit quiet,
                           input bit squeeze);
    int first;
    drain();
    set_regs(bl, rs, eh, er);
    calm = quiet;
    if (squeeze) hold_req = 1'b1;
    first = words_sent;
    while (words_sent - first < budget) run_sequence();
    calm = 1'b0;
  endtask

  initial begin
    int full;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: sets, holds, stray codes and patterns cut short
    send_word(ACT_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'h1F);
    send_word(ACT_SET, 16'h7FFF, 16'h8000, 16'd255, PAT_OFF);
    send_word(ACT_SET, 16'd256, 16'hFFFF, 16'd0, PAT_OFF);
    send_word(ACT_SET, 16'hFF00, 16'd128, 16'h7F00, PAT_OFF);
    send_word(ACT_START, 16'h0, 16'h0, 16'h0, PAT_OFF);
    for (int p = 1; p <= PAT_HOLD_LAST; p++) send_word(ACT_START, 16'h0, 16'h0, 16'h0, 5'(p));
    send_word(ACT_START, 16'h0, 16'h0, 16'h0, 5'd17);
    send_word(ACT_START, 16'h0, 16'h0, 16'h0, 5'd31);
    send_word(2'b11, 16'h1234, 16'h5678, 16'h9ABC, PAT_BLINK_FIRST);
    send_word(ACT_START, 16'h0, 16'h0, 16'h0, PAT_BLINK_FIRST);
    repeat (3) send_tick();
    send_word(ACT_START, 16'h0, 16'h0, 16'h0, PAT_ERROR);
    send_tick();
    send_word(ACT_START, 16'h0, 16'h0, 16'h0, PAT_RAINBOW);
    send_tick();
    send_word(ACT_START, 16'h0, 16'h0, 16'h0, PAT_START);
    send_word(ACT_SET, 16'hFFFB, 16'd300, 16'd77, PAT_START);
    send_word(ACT_START, 16'h0, 16'h0, 16'h0, PAT_FLASH_FIRST);
    send_word(ACT_START, 16'h0, 16'h0, 16'h0, PAT_REVERSE);
    send_word(ACT_START, 16'h0, 16'h0, 16'h0, PAT_FLASH_LAST);
    send_tick();

    run_phase(10'd1, 10'd1, 10'd1, 10'd1, 70, 1'b0, 1'b0);
    run_phase(10'd0, 10'd0, 10'd0, 10'd0, 40, 1'b0, 1'b0);
    run_phase(10'd3, 10'd2, 10'd4, 10'd2, 70, 1'b1, 1'b0);
    run_phase(10'($urandom_range(1, 6)), 10'($urandom_range(1, 6)), 10'($urandom_range(1, 6)),
              10'($urandom_range(1, 6)), 80, 1'b0, 1'b1);

    // rainbow through the whole first up-ramp and into the next ramp
    drain();
    set_regs(10'd2, 10'd1, 10'd1, 10'd3);
    full = 1 + 256 + 3;
    send_word(ACT_START, 16'h0, 16'h0, 16'h0, PAT_RAINBOW);
    repeat (full) send_tick();

    run_phase(10'd1023, 10'd63, 10'd255, 10'd1023, 25, 1'b0, 1'b0);
    run_phase(10'($urandom), 10'($urandom_range(0, 63)), 10'($urandom_range(0, 255)),
              10'($urandom), 40, 1'b0, 1'b1);

    drain();
    if (tracker.fails == 0 && tracker.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
